@@ design/iir_pkg.sv @@
// Shared types, widths and constants of the Direct Form I biquad filter.
package iir_pkg;

	localparam int SAMPLE_WIDTH    = 16;
	localparam int COEFF_WIDTH     = 18;
	localparam int COEFF_FRAC_BITS = 14;
	localparam int TAP_WIDTH       = 2;
	localparam int CFG_INDEX_WIDTH = 3;
	localparam int PROD_WIDTH      = SAMPLE_WIDTH + COEFF_WIDTH;
	localparam int ACC_WIDTH       = PROD_WIDTH + 3;

	localparam logic [TAP_WIDTH-1:0] TAP_COUNT_RESET = TAP_WIDTH'(3);

	// 1.0 in coefficient format, clamped to the largest coefficient
	localparam longint COEFF_ONE = longint'(1) << COEFF_FRAC_BITS;
	localparam longint COEFF_MAX = (longint'(1) << (COEFF_WIDTH - 1)) - 1;
	localparam logic signed [COEFF_WIDTH-1:0] COEFF_B0_RESET =
		COEFF_WIDTH'((COEFF_ONE > COEFF_MAX) ? COEFF_MAX : COEFF_ONE);

	localparam logic signed [ACC_WIDTH-1:0] ROUND_HALF =
		ACC_WIDTH'(longint'(1) << (COEFF_FRAC_BITS - 1));
	localparam logic signed [ACC_WIDTH-1:0] SAT_MAX =
		ACC_WIDTH'((longint'(1) << (SAMPLE_WIDTH - 1)) - 1);
	localparam logic signed [ACC_WIDTH-1:0] SAT_MIN = ~SAT_MAX;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_TAP_COUNT = 3'd0,
		REG_COEFF_B0  = 3'd1,
		REG_COEFF_B1  = 3'd2,
		REG_COEFF_B2  = 3'd3,
		REG_COEFF_A1  = 3'd4,
		REG_COEFF_A2  = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DRAIN,
		ST_ROUND
	} iir_state_t;

	typedef enum logic [2:0] {
		STEP_B0,
		STEP_B1,
		STEP_A1,
		STEP_B2,
		STEP_A2
	} mac_step_t;

	// control of the shared multiply-accumulate unit
	typedef struct packed {
		logic valid;
		logic first;
		logic neg;
	} mac_ctrl_t;

endpackage

@@ design/iir_sample_if.sv @@
// Input channel carrying one signed sample per item.
interface iir_sample_if import iir_pkg::*; ();
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

@@ design/iir_result_if.sv @@
// Output channel carrying one filtered sample and its clip flag per item.
interface iir_result_if import iir_pkg::*; ();
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_out;
	logic                           clipped;

	modport source (output valid, output sample_out, output clipped, input ready);
	modport sink (input valid, input sample_out, input clipped, output ready);
endinterface

@@ design/iir_cfg_if.sv @@
// Configuration write channel: register index and write data.
interface iir_cfg_if import iir_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic [CFG_INDEX_WIDTH-1:0]    index;
	logic signed [COEFF_WIDTH-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/iir_direct_form_one_filter.sv @@
// An accepted item is registered in x_q, then its five products go one per cycle through
// the single shared multiplier; a drain state lets the last product reach the sum, a round
// state rounds and saturates once the output register is free, and the idle state takes
// the next item. A new item is not taken before the last one has left the round state.
// The next item is taken while a finished result still waits to be taken.
// Reset (arst_n low, asynchronous): histories cleared, tap_count 3, b0 = 1.0, others 0.
module iir_direct_form_one_filter import iir_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	iir_sample_if.sink   samples,
	iir_result_if.source results,
	iir_cfg_if.sink      cfg
);

	iir_state_t                     state_q, state_d;
	mac_step_t                      step_q, step_d;
	mac_ctrl_t                      mac_ctrl;
	logic                           load_x;
	logic                           finish;

	logic [TAP_WIDTH-1:0]           tap_count_q;
	logic signed [COEFF_WIDTH-1:0]  coeff_b0_q, coeff_b1_q, coeff_b2_q;
	logic signed [COEFF_WIDTH-1:0]  coeff_a1_q, coeff_a2_q;

	logic signed [SAMPLE_WIDTH-1:0] x_q;
	logic signed [SAMPLE_WIDTH-1:0] xh0_q, xh1_q, yh0_q, yh1_q;

	logic signed [COEFF_WIDTH-1:0]  mac_coeff;
	logic signed [SAMPLE_WIDTH-1:0] mac_operand;
	logic signed [ACC_WIDTH-1:0]    acc;
	logic                           use_mid, use_far;

	logic signed [ACC_WIDTH-1:0]    rnd_sum, rnd_shift;
	logic signed [SAMPLE_WIDTH-1:0] y_sat;
	logic                           clip_d;

	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] y_q;
	logic                           clip_q;

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= TAP_COUNT_RESET;
			coeff_b0_q  <= COEFF_B0_RESET;
			coeff_b1_q  <= '0;
			coeff_b2_q  <= '0;
			coeff_a1_q  <= '0;
			coeff_a2_q  <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_TAP_COUNT: tap_count_q <= cfg.data[TAP_WIDTH-1:0];
				REG_COEFF_B0:  coeff_b0_q  <= cfg.data;
				REG_COEFF_B1:  coeff_b1_q  <= cfg.data;
				REG_COEFF_B2:  coeff_b2_q  <= cfg.data;
				REG_COEFF_A1:  coeff_a1_q  <= cfg.data;
				REG_COEFF_A2:  coeff_a2_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= STEP_B0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		step_d        = step_q;
		samples.ready = 1'b0;
		mac_ctrl      = '0;
		load_x        = 1'b0;
		finish        = 1'b0;
		case (state_q)
			ST_IDLE: begin
				samples.ready = 1'b1;
				if (samples.valid) begin
					load_x  = 1'b1;
					step_d  = STEP_B0;
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				mac_ctrl.valid = 1'b1;
				mac_ctrl.first = (step_q == STEP_B0);
				mac_ctrl.neg   = (step_q == STEP_A1) || (step_q == STEP_A2);
				if (step_q == STEP_A2) begin
					state_d = ST_DRAIN;
				end else begin
					step_d = mac_step_t'(step_q + 3'd1);
				end
			end
			ST_DRAIN: begin
				state_d = ST_ROUND;
			end
			ST_ROUND: begin
				// hold until the output register is free
				if (!out_valid_q || results.ready) begin
					finish  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// operand select; unused taps multiply by zero
	assign use_mid = tap_count_q[1];
	assign use_far = &tap_count_q;

	always_comb begin
		case (step_q)
			STEP_B0: begin
				mac_coeff   = coeff_b0_q;
				mac_operand = x_q;
			end
			STEP_B1: begin
				mac_coeff   = use_mid ? coeff_b1_q : '0;
				mac_operand = xh0_q;
			end
			STEP_A1: begin
				mac_coeff   = use_mid ? coeff_a1_q : '0;
				mac_operand = yh0_q;
			end
			STEP_B2: begin
				mac_coeff   = use_far ? coeff_b2_q : '0;
				mac_operand = xh1_q;
			end
			STEP_A2: begin
				mac_coeff   = use_far ? coeff_a2_q : '0;
				mac_operand = yh1_q;
			end
			default: begin
				mac_coeff   = '0;
				mac_operand = '0;
			end
		endcase
	end

	iir_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (mac_ctrl),
		.coeff   (mac_coeff),
		.operand (mac_operand),
		.acc     (acc)
	);

	// round half up, then saturate
	always_comb begin
		rnd_sum   = acc + ROUND_HALF;
		rnd_shift = rnd_sum >>> COEFF_FRAC_BITS;
		clip_d    = 1'b0;
		y_sat     = rnd_shift[SAMPLE_WIDTH-1:0];
		if (rnd_shift > SAT_MAX) begin
			y_sat  = SAT_MAX[SAMPLE_WIDTH-1:0];
			clip_d = 1'b1;
		end else if (rnd_shift < SAT_MIN) begin
			y_sat  = SAT_MIN[SAMPLE_WIDTH-1:0];
			clip_d = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_x) begin
			x_q <= samples.sample_in;
		end
	end

	// advance both histories once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xh0_q <= '0;
			xh1_q <= '0;
			yh0_q <= '0;
			yh1_q <= '0;
		end else if (finish) begin
			xh1_q <= xh0_q;
			xh0_q <= x_q;
			yh1_q <= yh0_q;
			yh0_q <= y_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			y_q    <= y_sat;
			clip_q <= clip_d;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.sample_out = y_q;
	assign results.clipped    = clip_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		samples.valid && samples.ready |=> state_q == ST_MUL && step_q == STEP_B0)
		else $error("accepted item did not start the product sequence");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROUND |->
			$past(state_q) == ST_DRAIN || $past(state_q) == ST_ROUND)
		else $error("rounding entered without draining the accumulator");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_ROUND)
		else $error("result appeared outside the rounding step");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && clip_q |->
			y_q == SAT_MAX[SAMPLE_WIDTH-1:0] || y_q == SAT_MIN[SAMPLE_WIDTH-1:0])
		else $error("clipped result is not at a saturation limit");

endmodule

@@ design/iir_mac.sv @@
// Shared multiply-accumulate unit: registered product, then add or subtract into the sum.
module iir_mac import iir_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mac_ctrl_t                     ctrl,
	input  logic signed [COEFF_WIDTH-1:0]  coeff,
	input  logic signed [SAMPLE_WIDTH-1:0] operand,
	output logic signed [ACC_WIDTH-1:0]    acc
);

	mac_ctrl_t                      ctrl_s1;
	logic signed [PROD_WIDTH-1:0]   prod_s1;
	logic signed [ACC_WIDTH-1:0]    acc_q;
	logic signed [ACC_WIDTH-1:0]    prod_ext;
	logic signed [ACC_WIDTH-1:0]    acc_base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1 <= ctrl;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.valid) begin
			prod_s1 <= coeff * operand;
		end
	end

	always_comb begin
		prod_ext = {{(ACC_WIDTH - PROD_WIDTH){prod_s1[PROD_WIDTH-1]}}, prod_s1};
		acc_base = ctrl_s1.first ? '0 : acc_q;
	end

	// first term of an item restarts the sum
	always_ff @(posedge clk) begin
		if (ctrl_s1.valid) begin
			acc_q <= ctrl_s1.neg ? (acc_base - prod_ext) : (acc_base + prod_ext);
		end
	end

	assign acc = acc_q;

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the Direct Form I biquad filter.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import iir_pkg::*;

	localparam logic [CFG_INDEX_WIDTH-1:0] IDX_SPARE_6 = 3'd6;
	localparam logic [CFG_INDEX_WIDTH-1:0] IDX_SPARE_7 = 3'd7;
	localparam logic signed [COEFF_WIDTH-1:0] C_MAX =
		COEFF_WIDTH'((1 <<< (COEFF_WIDTH - 1)) - 1);
	localparam logic signed [COEFF_WIDTH-1:0] C_MIN =
		COEFF_WIDTH'(-(1 <<< (COEFF_WIDTH - 1)));
	localparam logic signed [COEFF_WIDTH-1:0] C_ONE = COEFF_WIDTH'(1 <<< COEFF_FRAC_BITS);
	localparam logic signed [SAMPLE_WIDTH-1:0] S_MAX =
		SAMPLE_WIDTH'((1 <<< (SAMPLE_WIDTH - 1)) - 1);
	localparam logic signed [SAMPLE_WIDTH-1:0] S_MIN =
		SAMPLE_WIDTH'(-(1 <<< (SAMPLE_WIDTH - 1)));
	localparam int LATENCY_SLACK = 12;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] sample;
		logic                           clipped;
	} filt_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	iir_sample_if samples_if ();
	iir_result_if results_if ();
	iir_cfg_if    cfg_if ();

	iir_direct_form_one_filter u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_if),
		.results (results_if),
		.cfg     (cfg_if)
	);

	always #4 clk = ~clk;

	// filter copy: settings and delay lines
	logic [TAP_WIDTH-1:0]           taps_q;
	logic signed [COEFF_WIDTH-1:0]  b0_q, b1_q, b2_q, a1_q, a2_q;
	logic signed [SAMPLE_WIDTH-1:0] x_hist [2];
	logic signed [SAMPLE_WIDTH-1:0] y_hist [2];

	filt_out_t pending_out[$];
	int        errors = 0;
	bit        tx_gaps = 1'b0;
	bit        rx_stalls = 1'b0;
	int        hold_left = 0;
	int        stall_left = 0;

	task automatic report_mismatch(input string msg);
		if (errors < 40)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		errors++;
	endtask

	function automatic int random_gap();
		int r;
		r = $urandom_range(99, 0);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	function automatic logic signed [SAMPLE_WIDTH-1:0] rand_sample();
		case ($urandom_range(9, 0))
			0: return S_MAX;
			1: return S_MIN;
			2: return SAMPLE_WIDTH'(int'($urandom_range(255, 0)) - 128);
			default: return SAMPLE_WIDTH'($urandom);
		endcase
	endfunction

	function automatic logic signed [COEFF_WIDTH-1:0] rand_coeff();
		case ($urandom_range(7, 0))
			0: return C_MAX;
			1: return C_MIN;
			2: return '0;
			3, 4: return COEFF_WIDTH'(int'($urandom_range(32768, 0)) - 16384);
			default: return COEFF_WIDTH'($urandom);
		endcase
	endfunction

	function automatic void reset_filter();
		taps_q = TAP_COUNT_RESET;
		b0_q = COEFF_B0_RESET;
		b1_q = '0;
		b2_q = '0;
		a1_q = '0;
		a2_q = '0;
		x_hist = '{default: '0};
		y_hist = '{default: '0};
	endfunction

	// one sample through the filter copy; advances the delay lines
	function automatic filt_out_t filter_step(input logic signed [SAMPLE_WIDTH-1:0] x);
		filt_out_t            r;
		longint               acc;
		longint               y;
		logic [TAP_WIDTH-1:0] t;
		t = (taps_q == '0) ? TAP_WIDTH'(1) : taps_q;
		acc = longint'(b0_q) * longint'(x);
		if (t >= 2)
			acc += longint'(b1_q) * longint'(x_hist[0]) - longint'(a1_q) * longint'(y_hist[0]);
		if (t >= 3)
			acc += longint'(b2_q) * longint'(x_hist[1]) - longint'(a2_q) * longint'(y_hist[1]);
		acc += longint'(ROUND_HALF);
		y = acc >>> COEFF_FRAC_BITS;
		r.clipped = 1'b0;
		if (y > longint'(S_MAX)) begin
			y = longint'(S_MAX);
			r.clipped = 1'b1;
		end
		if (y < longint'(S_MIN)) begin
			y = longint'(S_MIN);
			r.clipped = 1'b1;
		end
		r.sample = SAMPLE_WIDTH'(y);
		x_hist[1] = x_hist[0];
		x_hist[0] = x;
		y_hist[1] = y_hist[0];
		y_hist[0] = r.sample;
		return r;
	endfunction

	// call at a clock edge; valid stays high afterwards for back-to-back items
	task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] s);
		int gap;
		gap = tx_gaps ? random_gap() : 0;
		if (gap > 0) begin
			samples_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		samples_if.valid <= 1'b1;
		samples_if.sample_in <= s;
		do @(posedge clk); while (!samples_if.ready);
		pending_out.push_back(filter_step(s));
	endtask

	// drop valid and hold until every expected item has come out
	task automatic wait_drained();
		samples_if.valid <= 1'b0;
		while (pending_out.size() != 0)
			@(posedge clk);
		repeat (LATENCY_SLACK) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
			input logic signed [COEFF_WIDTH-1:0] val, input bit last_one);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= val;
		do @(posedge clk); while (!cfg_if.ready);
		if (last_one)
			cfg_if.valid <= 1'b0;
		case (idx)
			REG_TAP_COUNT: taps_q = val[TAP_WIDTH-1:0];
			REG_COEFF_B0:  b0_q = val;
			REG_COEFF_B1:  b1_q = val;
			REG_COEFF_B2:  b2_q = val;
			REG_COEFF_A1:  a1_q = val;
			REG_COEFF_A2:  a2_q = val;
			default: ;
		endcase
	endtask

	task automatic program_filter(input logic signed [COEFF_WIDTH-1:0] taps_word,
			input logic signed [COEFF_WIDTH-1:0] b0, b1, b2, a1, a2);
		write_reg(REG_TAP_COUNT, taps_word, 1'b0);
		write_reg(REG_COEFF_B0, b0, 1'b0);
		write_reg(REG_COEFF_B1, b1, 1'b0);
		write_reg(REG_COEFF_B2, b2, 1'b0);
		write_reg(REG_COEFF_A1, a1, 1'b0);
		write_reg(REG_COEFF_A2, a2, 1'b1);
	endtask

	// reset settings pass samples through unchanged
	task automatic test_reset_passthrough();
		send_sample(S_MAX);
		send_sample(S_MIN);
		send_sample('0);
		send_sample(16'sd1);
		send_sample(-16'sd1);
		send_sample(16'sh5555);
		send_sample(16'shAAAA);
		wait_drained();
	endtask

	task automatic test_registers();
		// rounding at exactly one half, both signs
		program_filter(18'sd1, 18'sd1, '0, '0, '0, '0);
		send_sample(16'sd8192);
		send_sample(-16'sd8192);
		send_sample(16'sd8191);
		send_sample(-16'sd8193);
		wait_drained();
		// saturation high and low
		program_filter(18'sd3, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN);
		send_sample(S_MAX);
		send_sample(S_MIN);
		send_sample(S_MAX);
		wait_drained();
		program_filter(18'sd2, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
		send_sample(S_MAX);
		send_sample(S_MIN);
		send_sample(S_MAX);
		wait_drained();
		// tap count zero uses b0 alone; upper data bits are don't-care
		program_filter(18'sh3fffc, C_ONE, C_ONE, C_ONE, -C_ONE, -C_ONE);
		send_sample(16'sd1000);
		send_sample(-16'sd2000);
		wait_drained();
		// one tap, histories still shift and feed the next three-tap samples
		program_filter(18'sd1, C_ONE, 18'sd8192, 18'sd8192, -18'sd4096, 18'sd4096);
		send_sample(16'sd3000);
		send_sample(-16'sd7000);
		send_sample(16'sd12000);
		wait_drained();
		write_reg(REG_TAP_COUNT, 18'sd3, 1'b1);
		send_sample(16'sd500);
		send_sample(-16'sd500);
		wait_drained();
		// out-of-range indexes leave every setting alone
		write_reg(IDX_SPARE_6, 18'sh1ffff, 1'b0);
		write_reg(IDX_SPARE_7, -18'sd1, 1'b1);
		send_sample(16'sd4321);
		send_sample(S_MIN);
		wait_drained();
	endtask

	// stall the output long enough that the input backs up
	task automatic test_backpressure();
		program_filter(18'sd3, C_ONE >>> 1, C_ONE >>> 2, -(C_ONE >>> 2), C_ONE >>> 3, '0);
		tx_gaps = 1'b0;
		hold_left = 300;
		repeat (40)
			send_sample(rand_sample());
		wait_drained();
	endtask

	task automatic test_random();
		for (int phase = 0; phase < 14; phase++) begin
			wait_drained();
			if (phase == 0)
				program_filter(18'sd3, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
			else if (phase == 1)
				program_filter(18'sd3, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
			else
				program_filter(COEFF_WIDTH'($urandom), rand_coeff(), rand_coeff(),
					rand_coeff(), rand_coeff(), rand_coeff());
			tx_gaps = (phase % 4 != 0);
			rx_stalls = (phase % 4 != 0) && (phase % 3 != 2);
			for (int n = 0; n < 100; n++)
				send_sample(rand_sample());
		end
		tx_gaps = 1'b0;
		rx_stalls = 1'b0;
	endtask

	// output side: random stalls plus an occasional long hold-off
	always @(posedge clk) begin
		if (hold_left > 0) begin
			results_if.ready <= 1'b0;
			hold_left--;
		end else if (stall_left > 0) begin
			results_if.ready <= 1'b0;
			stall_left--;
		end else begin
			results_if.ready <= 1'b1;
			if (rx_stalls)
				stall_left = random_gap();
		end
	end

	always @(posedge clk) begin : check_results
		filt_out_t want;
		if (arst_n && results_if.valid && results_if.ready) begin
			if (pending_out.size() == 0) begin
				report_mismatch($sformatf("unexpected item sample_out=%0d",
					results_if.sample_out));
			end else begin
				want = pending_out.pop_front();
				if (results_if.sample_out !== want.sample)
					report_mismatch($sformatf("sample_out %0d, want %0d",
						results_if.sample_out, want.sample));
				if (results_if.clipped !== want.clipped)
					report_mismatch($sformatf("clipped %0b, want %0b",
						results_if.clipped, want.clipped));
			end
		end
	end

	initial begin
		#8000000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int waited;
		samples_if.valid = 1'b0;
		samples_if.sample_in = '0;
		results_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = '0;
		cfg_if.data = '0;
		reset_filter();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_passthrough();
		test_registers();
		test_backpressure();
		test_random();

		samples_if.valid <= 1'b0;
		waited = 0;
		while (pending_out.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (LATENCY_SLACK) @(posedge clk);
		if (pending_out.size() != 0)
			report_mismatch($sformatf("%0d items never came out", pending_out.size()));
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
